@@ hw/rtl/event_flag_group_macros.svh @@
// Assertion macros shared by the event flag group RTL.
`ifndef EVENT_FLAG_GROUP_MACROS_SVH
`define EVENT_FLAG_GROUP_MACROS_SVH

// Implication that must hold in the same cycle.
`define EFG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never occur.
`define EFG_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/efg_pkg.sv @@
// Types and constants shared by the event flag group modules.
`default_nettype none

package efg_pkg;

	localparam int TASK_W = 3;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		OP_WAIT    = 2'd0,
		OP_GIVE    = 2'd1,
		OP_KILL    = 2'd2,
		OP_TIMEOUT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RES_SUCCESS = 2'd0,
		RES_STOPPED = 2'd1,
		RES_TIMEOUT = 2'd2
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_SWEEP = 2'd1,
		BK_FLUSH = 2'd2
	} bk_state_t;

	typedef struct packed {
		op_t               op;
		logic [TASK_W-1:0] task_id;
		logic              wait_all;
		logic              ignore_held;
	} cmd_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} bk_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/efg_queue.sv @@
// Two-entry command queue between the front and back parts.
`default_nettype none

module efg_queue
	import efg_pkg::*;
#(
	parameter int DATA_W = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output q_stat_t                stat
);

	logic [DATA_W-1:0] mem [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign pop_data   = mem[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

@@ hw/rtl/efg_front.sv @@
// Front part: accepts requests, decodes them and queues the valid ones.
`default_nettype none

module efg_front
	import efg_pkg::*;
#(
	parameter int WAITERS   = 8,
	parameter int FLAG_BITS = 32,
	parameter int IN_W      = 40
) (
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [IN_W-1:0]           s_tdata,
	input  wire logic [1:0]                s_tuser,
	input  q_stat_t                        q_stat,
	output logic                           push,
	output logic [FLAG_BITS+$bits(cmd_ctl_t)-1:0] push_data
);

	localparam int CTL_W = $bits(cmd_ctl_t);

	cmd_ctl_t             ctl;
	logic [FLAG_BITS-1:0] flags;
	logic                 in_range;

	always_comb begin
		ctl.op          = op_t'(s_tuser);
		ctl.task_id     = s_tdata[TASK_W-1:0];
		ctl.wait_all    = s_tdata[TASK_W+FLAG_BITS];
		ctl.ignore_held = s_tdata[TASK_W+FLAG_BITS+1];
		flags           = s_tdata[TASK_W +: FLAG_BITS];
	end

	// Requests naming a slot beyond the table are dropped here.
	assign in_range  = (32'(ctl.task_id) < 32'(WAITERS));
	assign s_tready  = !q_stat.full;
	assign push      = s_tvalid && s_tready && in_range;
	assign push_data = {flags, ctl[CTL_W-1:0]};

endmodule

`default_nettype wire

@@ hw/rtl/efg_back.sv @@
// Back part: flag and waiter state, slot sweep and result register.
`default_nettype none

module efg_back
	import efg_pkg::*;
#(
	parameter int WAITERS   = 8,
	parameter int FLAG_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  q_stat_t                        q_stat,
	input  wire logic [FLAG_BITS+$bits(cmd_ctl_t)-1:0] q_data,
	output bk_stat_t                       stat,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [TASK_W-1:0]              m_task,
	output res_t                           m_res,
	output logic                           m_tlast
);

	localparam int CTL_W  = $bits(cmd_ctl_t);
	localparam int SLOT_W = $clog2(WAITERS);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(WAITERS - 1);

	bk_state_t            state_q;
	bk_state_t            state_nxt;
	op_t                  mode_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [FLAG_BITS-1:0] held_q;
	logic [FLAG_BITS-1:0] snap_q;
	logic [WAITERS-1:0]   valid_q;
	logic [FLAG_BITS-1:0] pend_q [WAITERS];
	logic                 all_q [WAITERS];

	logic                 pr_valid_q;
	logic [TASK_W-1:0]    pr_task_q;
	res_t                 pr_res_q;

	logic                 out_valid_q;
	logic [TASK_W-1:0]    out_task_q;
	res_t                 out_res_q;
	logic                 out_last_q;

	cmd_ctl_t             ctl;
	logic [FLAG_BITS-1:0] fl;
	logic [SLOT_W-1:0]    slot;
	logic                 out_free;
	logic [FLAG_BITS-1:0] w_pend;
	logic                 w_block;
	logic [FLAG_BITS-1:0] pend_rd;
	logic [FLAG_BITS-1:0] new_pend;
	logic                 sweep_hit;
	logic                 sweep_wake;

	logic                 pop;
	logic                 push_out;
	logic [TASK_W-1:0]    push_task;
	res_t                 push_res;
	logic                 push_last;
	logic                 gen;
	logic                 pr_clr;

	assign ctl      = cmd_ctl_t'(q_data[CTL_W-1:0]);
	assign fl       = q_data[CTL_W +: FLAG_BITS];
	assign slot     = SLOT_W'(ctl.task_id);
	assign out_free = !out_valid_q || m_tready;

	assign w_pend  = ctl.ignore_held ? fl : (fl & ~held_q);
	assign w_block = (w_pend != '0) && (ctl.wait_all || (w_pend == fl));

	assign pend_rd    = pend_q[idx_q];
	assign new_pend   = pend_rd & ~snap_q;
	assign sweep_hit  = valid_q[idx_q] && ((mode_q == OP_KILL) || ((pend_rd & snap_q) != '0));
	assign sweep_wake = (mode_q == OP_KILL) || (new_pend == '0) || !all_q[idx_q];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty && out_free && ((ctl.op == OP_GIVE) || (ctl.op == OP_KILL))) begin
					state_nxt = BK_SWEEP;
				end
			end
			BK_SWEEP: begin
				if (out_free && (idx_q == LAST_IDX)) begin
					state_nxt = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (out_free) begin
					state_nxt = BK_IDLE;
				end
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	// A sweep keeps its newest wakeup back until it knows whether another follows.
	always_comb begin
		pop       = 1'b0;
		push_out  = 1'b0;
		push_task = pr_task_q;
		push_res  = pr_res_q;
		push_last = 1'b0;
		gen       = 1'b0;
		pr_clr    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop       = !q_stat.empty && out_free;
				push_task = ctl.task_id;
				push_last = 1'b1;
				if (ctl.op == OP_WAIT) begin
					push_out = pop && !w_block;
					push_res = RES_SUCCESS;
				end else if (ctl.op == OP_TIMEOUT) begin
					push_out = pop && valid_q[slot];
					push_res = RES_TIMEOUT;
				end
			end
			BK_SWEEP: begin
				gen      = out_free && sweep_hit && sweep_wake;
				push_out = gen && pr_valid_q;
			end
			BK_FLUSH: begin
				push_out  = out_free && pr_valid_q;
				push_last = 1'b1;
				pr_clr    = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			mode_q      <= OP_GIVE;
			idx_q       <= '0;
			held_q      <= '0;
			valid_q     <= '0;
			pr_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (gen) begin
				pr_valid_q <= 1'b1;
			end else if (pr_clr) begin
				pr_valid_q <= 1'b0;
			end
			if (pop) begin
				idx_q <= '0;
				case (ctl.op)
					OP_WAIT: begin
						held_q        <= held_q & ~fl;
						valid_q[slot] <= w_block;
					end
					OP_GIVE: begin
						held_q <= held_q | fl;
						mode_q <= OP_GIVE;
					end
					OP_KILL: begin
						mode_q <= OP_KILL;
					end
					OP_TIMEOUT: begin
						valid_q[slot] <= 1'b0;
					end
					default: begin
						mode_q <= mode_q;
					end
				endcase
			end
			if ((state_q == BK_SWEEP) && out_free) begin
				idx_q <= idx_q + 1'b1;
				if (sweep_hit && (mode_q == OP_GIVE)) begin
					held_q <= held_q & ~pend_rd;
				end
				if (sweep_hit && sweep_wake) begin
					valid_q[idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (ctl.op == OP_GIVE)) begin
			snap_q <= held_q | fl;
		end
		if (pop && (ctl.op == OP_WAIT)) begin
			pend_q[slot] <= w_pend;
			all_q[slot]  <= ctl.wait_all;
		end else if ((state_q == BK_SWEEP) && out_free && sweep_hit && (mode_q == OP_GIVE)) begin
			pend_q[idx_q] <= new_pend;
		end
		if (gen) begin
			pr_task_q <= TASK_W'(idx_q);
			pr_res_q  <= (mode_q == OP_KILL) ? RES_STOPPED : RES_SUCCESS;
		end
		if (push_out) begin
			out_task_q <= push_task;
			out_res_q  <= push_res;
			out_last_q <= push_last;
		end
	end

	assign stat.idle = (state_q == BK_IDLE);
	assign stat.pop  = pop;
	assign m_tvalid  = out_valid_q;
	assign m_task    = out_task_q;
	assign m_res     = out_res_q;
	assign m_tlast   = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/event_flag_group.sv @@
// Event flag group with a table of waiting tasks.
//
// Requests enter on the s_ channel: s_tuser carries the operation (wait, give,
// kill, timeout) and s_tdata the slot, flag mask and wait options. Wakeups
// leave on the m_ channel, one per cycle at most, in slot order; m_tlast
// marks the final wakeup caused by one request, and a request may cause none.
// A two-entry queue separates request decoding from execution, so requests
// are taken while the executing part is busy or the output is stalled.
// A wait or timeout executes as it leaves the queue; its result is held in the
// result register, from which the m_ channel presents it.
// A give or kill sweeps the waiter table, one slot per cycle while the output
// is not stalled, and occupies the executing part until its final flush.
// Reset clears the held flags and all waiting entries.
// While a result waits and m_tready is low, the result register holds its value,
// execution stops, and requests are still taken until the queue is full.
`default_nettype none

module event_flag_group
	import efg_pkg::*;
#(
	parameter int WAITERS   = 8,
	parameter int FLAG_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// task_req[2:0], flags, wait_all, ignore_held, zero fill
	input  wire logic [((TASK_W+FLAG_BITS+2+7)/8)*8-1:0] s_tdata,
	// op[1:0]
	input  wire logic [1:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// woken_task[2:0], zero fill
	output logic [OUT_TDATA_W-1:0]   m_tdata,
	// event_res[1:0]
	output logic [1:0]               m_tuser,
	output logic                     m_tlast
);

	localparam int IN_W  = ((TASK_W + FLAG_BITS + 2 + 7) / 8) * 8;
	localparam int CMD_W = FLAG_BITS + $bits(cmd_ctl_t);

	q_stat_t           q_stat;
	bk_stat_t          bk_stat;
	logic              q_push;
	logic [CMD_W-1:0]  q_push_data;
	logic [CMD_W-1:0]  q_pop_data;
	logic [TASK_W-1:0] m_task;
	res_t              m_res;

	efg_front #(
		.WAITERS   (WAITERS),
		.FLAG_BITS (FLAG_BITS),
		.IN_W      (IN_W)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_data (q_push_data)
	);

	efg_queue #(
		.DATA_W (CMD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (bk_stat.pop),
		.pop_data  (q_pop_data),
		.stat      (q_stat)
	);

	efg_back #(
		.WAITERS   (WAITERS),
		.FLAG_BITS (FLAG_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.q_data   (q_pop_data),
		.stat     (bk_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_task   (m_task),
		.m_res    (m_res),
		.m_tlast  (m_tlast)
	);

	assign m_tdata = OUT_TDATA_W'(m_task);
	assign m_tuser = m_res;

`include "event_flag_group_macros.svh"

	`EFG_ASSERT_NEVER(a_q_overflow, q_push && q_stat.full, "Queue written while full.")
	`EFG_ASSERT_IMP(a_pop_nonempty, bk_stat.pop, !q_stat.empty, "Queue read while empty.")
	`EFG_ASSERT_IMP(a_pop_idle, bk_stat.pop, bk_stat.idle, "Request taken during a sweep.")

endmodule

`default_nettype wire
